[rtl/assert_macros.svh]
// assertion macros used by pearson_correlation
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALW(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pcorr_pkg.sv]
// pcorr_pkg: widths, codes and types of the pearson correlation block
// no dependencies
package pcorr_pkg;

    localparam int LIMB_BITS        = 32;
    localparam int WIDE_LIMBS       = 6;
    localparam int WIDE_BITS        = LIMB_BITS * WIDE_LIMBS;
    localparam int LIMB_IDX_BITS    = 3;
    localparam int MUL_BITS         = LIMB_BITS + 1;
    localparam int PROD_BITS        = 2 * MUL_BITS;

    localparam int PORT_SAMPLE_BITS = 16;
    localparam int CNT_W            = 25;
    localparam int SUM_W            = 50;
    localparam int SQ_W             = 55;
    localparam int XY_W             = 56;
    localparam int SQ_OUT_W         = 54;
    localparam int XY_OUT_W         = 55;
    localparam int CORR_W           = 16;

    localparam int VAR_W            = 3 * LIMB_BITS;
    localparam int DEN_W            = 5 * LIMB_BITS;
    localparam int Q_W              = 16;
    localparam int BIT_IDX_W        = 4;
    localparam int TGT_SHIFT        = 30;

    localparam logic [Q_W-1:0]    Q_MAX        = 16'd32768;
    localparam logic [CORR_W-1:0] CORR_POS_MAX = 16'h7fff;

    // index of the top limb for operands of one, two, three and five limbs
    localparam logic [LIMB_IDX_BITS-1:0] LAST_1 = 3'd0;
    localparam logic [LIMB_IDX_BITS-1:0] LAST_2 = 3'd1;
    localparam logic [LIMB_IDX_BITS-1:0] LAST_3 = 3'd2;
    localparam logic [LIMB_IDX_BITS-1:0] LAST_5 = 3'd4;

    typedef logic [WIDE_LIMBS-1:0][LIMB_BITS-1:0] t_wide;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_PXY,
        ST_ADDXY,
        ST_JOB,
        ST_MUL,
        ST_ADD,
        ST_POST,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        JB_NSXY,
        JB_SXSY,
        JB_NSXX,
        JB_SXSX,
        JB_NSYY,
        JB_SYSY,
        JB_DEN,
        JB_TGT,
        JB_SQ,
        JB_SQDEN
    } t_job;

endpackage

[rtl/pearson_correlation.sv]
// pearson_correlation: streaming pearson coefficient over pairs of q8.8 samples
// depends on pcorr_pkg and assert_macros.svh
//
// A pair is taken when start is high and busy is low. Every pair goes through one
// shared 33x33 multiplier for x*x, y*y and x*y, and busy stays high until their sums
// are updated, so no new pair is taken before then. On the pair marked last the same
// multiplier works limb by limb (each 32x32-bit limb product is registered, then
// added into a 192-bit sum) through the variance and covariance terms and a 16-step
// bit search for r; the result strobe o_valid rises when the search ends, or after
// the variance terms if a variance is zero. o_valid is high for exactly one cycle and
// cannot be held off, and the sums are cleared for the next vector at that time.
// Once 2^COUNT_BITS pairs are summed, further pairs are ignored until the last one.
`include "assert_macros.svh"

module pearson_correlation #(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [pcorr_pkg::PORT_SAMPLE_BITS-1:0] i_x_sample,
    input  logic signed [pcorr_pkg::PORT_SAMPLE_BITS-1:0] i_y_sample,
    input  logic                                        i_last_pair,
    output logic                                        o_valid,
    output logic signed [pcorr_pkg::CORR_W-1:0]         o_corr_r,
    output logic                                        o_zero_variance,
    output logic        [pcorr_pkg::CNT_W-1:0]          o_pair_count,
    output logic signed [pcorr_pkg::SUM_W-1:0]          o_total_x,
    output logic signed [pcorr_pkg::SUM_W-1:0]          o_total_y,
    output logic        [pcorr_pkg::SQ_OUT_W-1:0]       o_total_xx,
    output logic        [pcorr_pkg::SQ_OUT_W-1:0]       o_total_yy,
    output logic signed [pcorr_pkg::XY_OUT_W-1:0]       o_total_xy
);

    localparam int W_LIMB = pcorr_pkg::LIMB_BITS;
    localparam int W_WIDE = pcorr_pkg::WIDE_BITS;
    localparam int W_IDX  = pcorr_pkg::LIMB_IDX_BITS;
    localparam int W_MUL  = pcorr_pkg::MUL_BITS;
    localparam int W_PROD = pcorr_pkg::PROD_BITS;
    localparam int W_CNT  = pcorr_pkg::CNT_W;
    localparam int W_SUM  = pcorr_pkg::SUM_W;
    localparam int W_SQ   = pcorr_pkg::SQ_W;
    localparam int W_XY   = pcorr_pkg::XY_W;
    localparam int W_SQO  = pcorr_pkg::SQ_OUT_W;
    localparam int W_XYO  = pcorr_pkg::XY_OUT_W;
    localparam int W_CORR = pcorr_pkg::CORR_W;
    localparam int W_VAR  = pcorr_pkg::VAR_W;
    localparam int W_DEN  = pcorr_pkg::DEN_W;
    localparam int W_Q    = pcorr_pkg::Q_W;
    localparam int W_BIT  = pcorr_pkg::BIT_IDX_W;

    localparam logic [W_CNT-1:0] CNT_LIMIT = W_CNT'(1) << COUNT_BITS;

    // control
    pcorr_pkg::t_state r_state, n_state;
    pcorr_pkg::t_job   r_job;
    logic              r_valid;
    logic [W_CNT-1:0]  r_acc_count;
    logic [W_SUM-1:0]  r_acc_x, r_acc_y;
    logic [W_SQ-1:0]   r_acc_xx, r_acc_yy;
    logic [W_XY-1:0]   r_acc_xy;
    logic [W_Q-1:0]    r_q;

    // datapath
    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic                          r_last, r_take;
    pcorr_pkg::t_wide              r_opa, r_opb;
    logic [W_IDX-1:0]              r_i, r_j, r_alast, r_blast;
    logic                          r_sub;
    logic signed [W_PROD-1:0]      r_pp;
    logic [W_WIDE-1:0]             r_wacc;
    logic                          r_nneg, r_zero;
    logic [W_VAR-1:0]              r_mag, r_va, r_vb;
    logic [W_DEN-1:0]              r_den;
    logic [W_WIDE-1:0]             r_tgt;
    logic [W_LIMB-1:0]             r_sq;
    logic [W_BIT-1:0]              r_bit;

    // result registers
    logic [W_CORR-1:0] r_out_corr;
    logic              r_out_zero;
    logic [W_CNT-1:0]  r_out_count;
    logic [W_SUM-1:0]  r_out_x, r_out_y;
    logic [W_SQO-1:0]  r_out_xx, r_out_yy;
    logic [W_XYO-1:0]  r_out_xy;

    logic signed [SAMPLE_BITS-1:0] x_in, y_in;
    logic                          take;
    logic [W_XY-1:0]               xy_mag;
    logic [W_SUM-1:0]              x_mag, y_mag;
    logic [W_Q-1:0]                cand;
    logic signed [W_MUL-1:0]       mul_a, mul_b;
    logic signed [W_PROD-1:0]      mul_p;
    logic [W_IDX:0]                limb_sum;
    logic [W_WIDE-1:0]             pp_sh;
    logic [W_WIDE-1:0]             wacc_abs;
    logic                          i_end, j_end;
    logic                          fits;
    logic                          var_zero;
    logic [W_CORR-1:0]             corr_val;
    logic [W_SQO-1:0]              xx_sat, yy_sat;
    logic [W_XYO-1:0]              xy_sat;

    assign x_in     = i_x_sample[SAMPLE_BITS-1:0];
    assign y_in     = i_y_sample[SAMPLE_BITS-1:0];
    assign take     = r_acc_count < CNT_LIMIT;
    assign xy_mag   = r_acc_xy[W_XY-1] ? W_XY'(-r_acc_xy) : r_acc_xy;
    assign x_mag    = r_acc_x[W_SUM-1] ? W_SUM'(-r_acc_x) : r_acc_x;
    assign y_mag    = r_acc_y[W_SUM-1] ? W_SUM'(-r_acc_y) : r_acc_y;
    assign cand     = r_q | (W_Q'(1) << r_bit);
    assign mul_p    = mul_a * mul_b;
    assign limb_sum = {1'b0, r_i} + {1'b0, r_j};
    assign pp_sh    = W_WIDE'(r_pp[2*W_LIMB-1:0]) << (W_LIMB * limb_sum);
    assign wacc_abs = r_wacc[W_WIDE-1] ? W_WIDE'(-r_wacc) : r_wacc;
    assign i_end    = r_i == r_alast;
    assign j_end    = r_j == r_blast;
    assign fits     = r_wacc <= r_tgt;
    assign var_zero = (r_va == '0) || (r_wacc[W_VAR-1:0] == '0);

    // shared multiplier operands
    always_comb begin
        unique case (r_state)
            pcorr_pkg::ST_SQX: begin
                mul_a = W_MUL'(r_x);
                mul_b = W_MUL'(r_x);
            end
            pcorr_pkg::ST_SQY: begin
                mul_a = W_MUL'(r_y);
                mul_b = W_MUL'(r_y);
            end
            pcorr_pkg::ST_PXY: begin
                mul_a = W_MUL'(r_x);
                mul_b = W_MUL'(r_y);
            end
            default: begin
                mul_a = $signed({1'b0, r_opa[r_i]});
                mul_b = $signed({1'b0, r_opb[r_j]});
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcorr_pkg::ST_IDLE:  if (start) n_state = pcorr_pkg::ST_SQX;
            pcorr_pkg::ST_SQX:   n_state = pcorr_pkg::ST_SQY;
            pcorr_pkg::ST_SQY:   n_state = pcorr_pkg::ST_PXY;
            pcorr_pkg::ST_PXY:   n_state = pcorr_pkg::ST_ADDXY;
            pcorr_pkg::ST_ADDXY: n_state = r_last ? pcorr_pkg::ST_JOB : pcorr_pkg::ST_IDLE;
            pcorr_pkg::ST_JOB:   n_state = pcorr_pkg::ST_MUL;
            pcorr_pkg::ST_MUL:   n_state = pcorr_pkg::ST_ADD;
            pcorr_pkg::ST_ADD:   n_state = (i_end && j_end) ? pcorr_pkg::ST_POST
                                                            : pcorr_pkg::ST_MUL;
            pcorr_pkg::ST_POST: begin
                if ((r_job == pcorr_pkg::JB_SYSY && var_zero) ||
                    (r_job == pcorr_pkg::JB_SQDEN && r_bit == '0)) begin
                    n_state = pcorr_pkg::ST_FIN;
                end else begin
                    n_state = pcorr_pkg::ST_JOB;
                end
            end
            pcorr_pkg::ST_FIN:   n_state = pcorr_pkg::ST_IDLE;
            default:             n_state = pcorr_pkg::ST_IDLE;
        endcase
    end

    // outputs and result shaping
    always_comb begin
        busy = r_state != pcorr_pkg::ST_IDLE;
        priority if (r_zero) begin
            corr_val = '0;
        end else if (r_nneg) begin
            corr_val = W_CORR'(-r_q);
        end else if (r_q > pcorr_pkg::CORR_POS_MAX) begin
            corr_val = pcorr_pkg::CORR_POS_MAX;
        end else begin
            corr_val = r_q;
        end
        xx_sat = r_acc_xx[W_SQ-1] ? {W_SQO{1'b1}} : r_acc_xx[W_SQO-1:0];
        yy_sat = r_acc_yy[W_SQ-1] ? {W_SQO{1'b1}} : r_acc_yy[W_SQO-1:0];
        priority if (r_acc_xy[W_XY-1:W_XY-2] == 2'b01) begin
            xy_sat = {1'b0, {(W_XYO-1){1'b1}}};
        end else if (r_acc_xy[W_XY-1:W_XY-2] == 2'b10) begin
            xy_sat = {1'b1, {(W_XYO-1){1'b0}}};
        end else begin
            xy_sat = r_acc_xy[W_XYO-1:0];
        end
    end

    // control registers and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcorr_pkg::ST_IDLE;
            r_job       <= pcorr_pkg::JB_NSXY;
            r_valid     <= 1'b0;
            r_acc_count <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_xx    <= '0;
            r_acc_yy    <= '0;
            r_acc_xy    <= '0;
            r_q         <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == pcorr_pkg::ST_FIN;
            unique case (r_state)
                pcorr_pkg::ST_IDLE: begin
                    if (start && take) begin
                        r_acc_count <= r_acc_count + 1'b1;
                        r_acc_x     <= r_acc_x + W_SUM'(x_in);
                        r_acc_y     <= r_acc_y + W_SUM'(y_in);
                    end
                end
                pcorr_pkg::ST_SQY: if (r_take) r_acc_xx <= r_acc_xx + r_pp[W_SQ-1:0];
                pcorr_pkg::ST_PXY: if (r_take) r_acc_yy <= r_acc_yy + r_pp[W_SQ-1:0];
                pcorr_pkg::ST_ADDXY: begin
                    if (r_take) r_acc_xy <= r_acc_xy + r_pp[W_XY-1:0];
                    r_job <= pcorr_pkg::JB_NSXY;
                end
                pcorr_pkg::ST_POST: begin
                    unique case (r_job)
                        pcorr_pkg::JB_NSXY: r_job <= pcorr_pkg::JB_SXSY;
                        pcorr_pkg::JB_SXSY: r_job <= pcorr_pkg::JB_NSXX;
                        pcorr_pkg::JB_NSXX: r_job <= pcorr_pkg::JB_SXSX;
                        pcorr_pkg::JB_SXSX: r_job <= pcorr_pkg::JB_NSYY;
                        pcorr_pkg::JB_NSYY: r_job <= pcorr_pkg::JB_SYSY;
                        pcorr_pkg::JB_SYSY: r_job <= pcorr_pkg::JB_DEN;
                        pcorr_pkg::JB_DEN:  r_job <= pcorr_pkg::JB_TGT;
                        pcorr_pkg::JB_TGT: begin
                            r_job <= pcorr_pkg::JB_SQ;
                            r_q   <= '0;
                        end
                        pcorr_pkg::JB_SQ:   r_job <= pcorr_pkg::JB_SQDEN;
                        pcorr_pkg::JB_SQDEN: begin
                            r_job <= pcorr_pkg::JB_SQ;
                            if (fits) r_q <= cand;
                        end
                        default:            r_job <= pcorr_pkg::JB_NSXY;
                    endcase
                end
                pcorr_pkg::ST_FIN: begin
                    r_acc_count <= '0;
                    r_acc_x     <= '0;
                    r_acc_y     <= '0;
                    r_acc_xx    <= '0;
                    r_acc_yy    <= '0;
                    r_acc_xy    <= '0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pcorr_pkg::ST_IDLE: begin
                if (start) begin
                    r_x    <= x_in;
                    r_y    <= y_in;
                    r_last <= i_last_pair;
                    r_take <= take;
                end
            end
            pcorr_pkg::ST_SQX, pcorr_pkg::ST_SQY, pcorr_pkg::ST_PXY,
            pcorr_pkg::ST_MUL: r_pp <= mul_p;
            pcorr_pkg::ST_JOB: begin
                r_i <= '0;
                r_j <= '0;
                if (r_job != pcorr_pkg::JB_SXSY && r_job != pcorr_pkg::JB_SXSX &&
                    r_job != pcorr_pkg::JB_SYSY) begin
                    r_wacc <= '0;
                end
                unique case (r_job)
                    pcorr_pkg::JB_NSXY: begin
                        r_opa   <= pcorr_pkg::t_wide'(xy_mag);
                        r_alast <= pcorr_pkg::LAST_2;
                        r_opb   <= pcorr_pkg::t_wide'(r_acc_count);
                        r_blast <= pcorr_pkg::LAST_1;
                        r_sub   <= r_acc_xy[W_XY-1];
                    end
                    pcorr_pkg::JB_SXSY: begin
                        r_opa   <= pcorr_pkg::t_wide'(x_mag);
                        r_alast <= pcorr_pkg::LAST_2;
                        r_opb   <= pcorr_pkg::t_wide'(y_mag);
                        r_blast <= pcorr_pkg::LAST_2;
                        r_sub   <= ~(r_acc_x[W_SUM-1] ^ r_acc_y[W_SUM-1]);
                    end
                    pcorr_pkg::JB_NSXX: begin
                        r_opa   <= pcorr_pkg::t_wide'(r_acc_xx);
                        r_alast <= pcorr_pkg::LAST_2;
                        r_opb   <= pcorr_pkg::t_wide'(r_acc_count);
                        r_blast <= pcorr_pkg::LAST_1;
                        r_sub   <= 1'b0;
                    end
                    pcorr_pkg::JB_SXSX: begin
                        r_opa   <= pcorr_pkg::t_wide'(x_mag);
                        r_alast <= pcorr_pkg::LAST_2;
                        r_opb   <= pcorr_pkg::t_wide'(x_mag);
                        r_blast <= pcorr_pkg::LAST_2;
                        r_sub   <= 1'b1;
                    end
                    pcorr_pkg::JB_NSYY: begin
                        r_opa   <= pcorr_pkg::t_wide'(r_acc_yy);
                        r_alast <= pcorr_pkg::LAST_2;
                        r_opb   <= pcorr_pkg::t_wide'(r_acc_count);
                        r_blast <= pcorr_pkg::LAST_1;
                        r_sub   <= 1'b0;
                    end
                    pcorr_pkg::JB_SYSY: begin
                        r_opa   <= pcorr_pkg::t_wide'(y_mag);
                        r_alast <= pcorr_pkg::LAST_2;
                        r_opb   <= pcorr_pkg::t_wide'(y_mag);
                        r_blast <= pcorr_pkg::LAST_2;
                        r_sub   <= 1'b1;
                    end
                    pcorr_pkg::JB_DEN: begin
                        r_opa   <= pcorr_pkg::t_wide'(r_va);
                        r_alast <= pcorr_pkg::LAST_3;
                        r_opb   <= pcorr_pkg::t_wide'(r_vb);
                        r_blast <= pcorr_pkg::LAST_3;
                        r_sub   <= 1'b0;
                    end
                    pcorr_pkg::JB_TGT: begin
                        r_opa   <= pcorr_pkg::t_wide'(r_mag);
                        r_alast <= pcorr_pkg::LAST_3;
                        r_opb   <= pcorr_pkg::t_wide'(r_mag);
                        r_blast <= pcorr_pkg::LAST_3;
                        r_sub   <= 1'b0;
                    end
                    pcorr_pkg::JB_SQ: begin
                        r_opa   <= pcorr_pkg::t_wide'(cand);
                        r_alast <= pcorr_pkg::LAST_1;
                        r_opb   <= pcorr_pkg::t_wide'(cand);
                        r_blast <= pcorr_pkg::LAST_1;
                        r_sub   <= 1'b0;
                    end
                    default: begin
                        r_opa   <= pcorr_pkg::t_wide'(r_sq);
                        r_alast <= pcorr_pkg::LAST_1;
                        r_opb   <= pcorr_pkg::t_wide'(r_den);
                        r_blast <= pcorr_pkg::LAST_5;
                        r_sub   <= 1'b0;
                    end
                endcase
            end
            pcorr_pkg::ST_ADD: begin
                r_wacc <= r_sub ? r_wacc - pp_sh : r_wacc + pp_sh;
                if (j_end) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            pcorr_pkg::ST_POST: begin
                unique case (r_job)
                    pcorr_pkg::JB_SXSY: begin
                        r_nneg <= r_wacc[W_WIDE-1];
                        r_mag  <= wacc_abs[W_VAR-1:0];
                    end
                    pcorr_pkg::JB_SXSX: r_va <= r_wacc[W_VAR-1:0];
                    pcorr_pkg::JB_SYSY: begin
                        r_vb   <= r_wacc[W_VAR-1:0];
                        r_zero <= var_zero;
                    end
                    pcorr_pkg::JB_DEN:  r_den <= r_wacc[W_DEN-1:0];
                    pcorr_pkg::JB_TGT: begin
                        r_tgt <= r_wacc << pcorr_pkg::TGT_SHIFT;
                        r_bit <= W_BIT'(W_Q - 1);
                    end
                    pcorr_pkg::JB_SQ:    r_sq  <= r_wacc[W_LIMB-1:0];
                    pcorr_pkg::JB_SQDEN: r_bit <= r_bit - 1'b1;
                    default: ;
                endcase
            end
            pcorr_pkg::ST_FIN: begin
                r_out_corr  <= corr_val;
                r_out_zero  <= r_zero;
                r_out_count <= r_acc_count;
                r_out_x     <= r_acc_x;
                r_out_y     <= r_acc_y;
                r_out_xx    <= xx_sat;
                r_out_yy    <= yy_sat;
                r_out_xy    <= xy_sat;
            end
            default: ;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_corr_r        = r_out_corr;
    assign o_zero_variance = r_out_zero;
    assign o_pair_count    = r_out_count;
    assign o_total_x       = r_out_x;
    assign o_total_y       = r_out_y;
    assign o_total_xx      = r_out_xx;
    assign o_total_yy      = r_out_yy;
    assign o_total_xy      = r_out_xy;

    `ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")
    `ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "transfer did not raise busy")
    `ASSERT_IMP(a_sums_cleared, i_clk, i_rst_n, o_valid, r_acc_count == '0, "sums kept after result")
    `ASSERT_IMP(a_zero_r, i_clk, i_rst_n, o_valid && o_zero_variance, o_corr_r == '0, "r not zero on zero variance")
    `ASSERT_ALW(a_q_range, i_clk, i_rst_n, r_q <= pcorr_pkg::Q_MAX, "search result above one")

endmodule

[tb/sv/tb_pearson_correlation.sv]
`timescale 1ns / 100ps
// tb_pearson_correlation: self-checking testbench for the streaming pearson correlation block
// depends on pcorr_pkg and pearson_correlation; predicts each vector result with exact wide math
module tb_pearson_correlation;

    localparam int PAIR_COUNT_BITS = 24;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int RANDOM_PAIRS    = 1150;
    localparam int DRAIN_CYCLES    = 400;
    localparam int CYCLE_LIMIT     = 2000000;

    typedef struct {
        logic signed [pcorr_pkg::CORR_W-1:0]   corr_r;
        logic                                  zero_var;
        logic [pcorr_pkg::CNT_W-1:0]           pair_count;
        logic signed [pcorr_pkg::SUM_W-1:0]    total_x;
        logic signed [pcorr_pkg::SUM_W-1:0]    total_y;
        logic [pcorr_pkg::SQ_OUT_W-1:0]        total_xx;
        logic [pcorr_pkg::SQ_OUT_W-1:0]        total_yy;
        logic signed [pcorr_pkg::XY_OUT_W-1:0] total_xy;
    } t_corr_result;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_TRACK,
        SHAPE_MIRROR,
        SHAPE_FLAT,
        SHAPE_TINY
    } t_vec_shape;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [pcorr_pkg::PORT_SAMPLE_BITS-1:0] i_x_sample;
    logic signed [pcorr_pkg::PORT_SAMPLE_BITS-1:0] i_y_sample;
    logic i_last_pair;
    logic o_valid;
    logic signed [pcorr_pkg::CORR_W-1:0]   o_corr_r;
    logic                                  o_zero_variance;
    logic [pcorr_pkg::CNT_W-1:0]           o_pair_count;
    logic signed [pcorr_pkg::SUM_W-1:0]    o_total_x;
    logic signed [pcorr_pkg::SUM_W-1:0]    o_total_y;
    logic [pcorr_pkg::SQ_OUT_W-1:0]        o_total_xx;
    logic [pcorr_pkg::SQ_OUT_W-1:0]        o_total_yy;
    logic signed [pcorr_pkg::XY_OUT_W-1:0] o_total_xy;

    longint sum_n, sum_x, sum_y, sum_xx, sum_yy, sum_xy;
    t_corr_result pending_results[$];
    t_corr_result want;

    int mismatches   = 0;
    int results_seen = 0;
    int pairs_sent   = 0;
    int flat_results = 0;
    int unity_pos    = 0;
    int unity_neg    = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    pearson_correlation #(
        .COUNT_BITS  (PAIR_COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_x_sample      (i_x_sample),
        .i_y_sample      (i_y_sample),
        .i_last_pair     (i_last_pair),
        .o_valid         (o_valid),
        .o_corr_r        (o_corr_r),
        .o_zero_variance (o_zero_variance),
        .o_pair_count    (o_pair_count),
        .o_total_x       (o_total_x),
        .o_total_y       (o_total_y),
        .o_total_xx      (o_total_xx),
        .o_total_yy      (o_total_yy),
        .o_total_xy      (o_total_xy)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic longint sext_sample(input logic [pcorr_pkg::PORT_SAMPLE_BITS-1:0] raw);
        longint v;
        v = longint'(raw) & ((64'sd1 <<< SAMPLE_WIDTH) - 1);
        if (v[SAMPLE_WIDTH-1])
            v = v - (64'sd1 <<< SAMPLE_WIDTH);
        return v;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic void accumulate_pair(input logic [pcorr_pkg::PORT_SAMPLE_BITS-1:0] xs,
                                            input logic [pcorr_pkg::PORT_SAMPLE_BITS-1:0] ys);
        longint x, y;
        x = sext_sample(xs);
        y = sext_sample(ys);
        if (sum_n < (64'sd1 <<< PAIR_COUNT_BITS)) begin
            sum_n  = sum_n + 1;
            sum_x  = sum_x + x;
            sum_y  = sum_y + y;
            sum_xx = sum_xx + x * x;
            sum_yy = sum_yy + y * y;
            sum_xy = sum_xy + x * y;
        end
    endfunction

    // exact r in q1.15 by a binary search on r^2 * den <= num^2, then clear the sums
    function automatic t_corr_result close_vector();
        t_corr_result res;
        logic signed [255:0] n, sx, sy, num, va, vb;
        logic [255:0] mag, tgt, den, sq, t;
        int unsigned lo, hi, mid;
        logic neg;
        longint sq_max, xy_min;
        n   = 256'(sum_n);
        sx  = 256'(sum_x);
        sy  = 256'(sum_y);
        num = n * 256'(signed'(sum_xy)) - sx * sy;
        va  = n * 256'(signed'(sum_xx)) - sx * sx;
        vb  = n * 256'(signed'(sum_yy)) - sy * sy;
        res.corr_r   = '0;
        res.zero_var = 1'b0;
        if (va == 0 || vb == 0) begin
            res.zero_var = 1'b1;
        end else begin
            neg = num < 0;
            mag = neg ? -num : num;
            tgt = (mag * mag) << pcorr_pkg::TGT_SHIFT;
            den = va * vb;
            lo = 0;
            hi = 32768;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                sq  = 256'(mid) * 256'(mid);
                t   = sq * den;
                if (t <= tgt) lo = mid;
                else hi = mid - 1;
            end
            if (neg) res.corr_r = 16'(65536 - lo);
            else res.corr_r = (lo > 32767) ? pcorr_pkg::CORR_POS_MAX : 16'(lo);
        end
        sq_max = (64'sd1 <<< pcorr_pkg::SQ_OUT_W) - 1;
        xy_min = -(64'sd1 <<< (pcorr_pkg::XY_OUT_W - 1));
        res.pair_count = sum_n[pcorr_pkg::CNT_W-1:0];
        res.total_x    = sum_x[pcorr_pkg::SUM_W-1:0];
        res.total_y    = sum_y[pcorr_pkg::SUM_W-1:0];
        res.total_xx   = (sum_xx > sq_max) ? sq_max[pcorr_pkg::SQ_OUT_W-1:0]
                                           : sum_xx[pcorr_pkg::SQ_OUT_W-1:0];
        res.total_yy   = (sum_yy > sq_max) ? sq_max[pcorr_pkg::SQ_OUT_W-1:0]
                                           : sum_yy[pcorr_pkg::SQ_OUT_W-1:0];
        if (sum_xy > -xy_min - 1) res.total_xy = pcorr_pkg::XY_OUT_W'(-xy_min - 1);
        else if (sum_xy < xy_min) res.total_xy = pcorr_pkg::XY_OUT_W'(xy_min);
        else res.total_xy = sum_xy[pcorr_pkg::XY_OUT_W-1:0];
        sum_n  = 0;
        sum_x  = 0;
        sum_y  = 0;
        sum_xx = 0;
        sum_yy = 0;
        sum_xy = 0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatches < 40)
            $display("mismatch in result %0d: %s got %h want %h",
                     results_seen, what, got, exp_val);
        mismatches++;
    endtask

    // one transfer, then the sender pacing: bursts of random length with random gaps
    task automatic send_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                             input logic last);
        int gap;
        start       <= 1'b1;
        i_x_sample  <= xs;
        i_y_sample  <= ys;
        i_last_pair <= last;
        do @(posedge i_clk); while (busy);
        accumulate_pair(xs, ys);
        pairs_sent++;
        if (last)
            pending_results.push_back(close_vector());
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
            gap = $urandom_range(1, 14);
            start       <= 1'b0;
            i_x_sample  <= 16'($urandom);
            i_y_sample  <= 16'($urandom);
            i_last_pair <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_vector(input t_vec_shape shape, input int len);
        logic signed [15:0] xs, ys, held;
        int noise;
        held = 16'($urandom);
        for (int k = 0; k < len; k++) begin
            xs = 16'($urandom);
            ys = 16'($urandom);
            noise = int'($urandom_range(0, 128)) - 64;
            case (shape)
                SHAPE_TRACK: begin
                    ys = clamp16(int'(xs) + noise);
                end
                SHAPE_MIRROR: begin
                    ys = clamp16(-int'(xs) + noise);
                end
                SHAPE_FLAT: begin
                    if (held[0]) xs = held;
                    else ys = held;
                end
                SHAPE_TINY: begin
                    xs = clamp16(int'($urandom_range(0, 16)) - 8);
                    ys = clamp16(int'($urandom_range(0, 16)) - 8);
                end
                default: begin
                end
            endcase
            send_pair(xs, ys, k == len - 1);
        end
    endtask

    task automatic test_single_pair();
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_constant_vector();
        send_pair(16'sd5, 16'sd1, 1'b0);
        send_pair(16'sd5, -16'sd2, 1'b0);
        send_pair(16'sd5, 16'sd3, 1'b1);
        send_pair(16'sd7, -16'sd1, 1'b0);
        send_pair(-16'sd9, -16'sd1, 1'b1);
    endtask

    task automatic test_perfect_positive();
        send_pair(-16'sd32768, -16'sd32768, 1'b0);
        send_pair(16'sd32767, 16'sd32767, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_perfect_negative();
        send_pair(16'sd100, -16'sd100, 1'b0);
        send_pair(-16'sd200, 16'sd200, 1'b0);
        send_pair(16'sd32767, -16'sd32767, 1'b1);
    endtask

    task automatic test_extreme_samples();
        send_pair(16'sd32767, -16'sd32768, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, 1'b0);
        send_pair(16'sd32767, 16'sd32767, 1'b0);
        send_pair(-16'sd32768, -16'sd32768, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
    endtask

    task automatic test_drain_pause();
        wait_for_results();
        send_pair(16'sd300, 16'sd299, 1'b0);
        send_pair(-16'sd300, -16'sd1, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_vectors();
        int goal, len, pick;
        goal = pairs_sent + RANDOM_PAIRS;
        while (pairs_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) len = $urandom_range(1, 2);
            else if (pick < 10) len = $urandom_range(100, 250);
            else len = $urandom_range(3, 24);
            if (len > goal - pairs_sent) len = goal - pairs_sent;
            send_vector(t_vec_shape'($urandom_range(0, 4)), len);
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no open vector", 64'(o_corr_r), 64'd0);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.zero_var) flat_results++;
                if (!want.zero_var && want.corr_r == pcorr_pkg::CORR_POS_MAX) unity_pos++;
                if (want.corr_r == -16'sd32768) unity_neg++;
                if (o_corr_r !== want.corr_r)
                    report_mismatch("corr_r", 64'(o_corr_r), 64'(want.corr_r));
                if (o_zero_variance !== want.zero_var)
                    report_mismatch("zero_variance", 64'(o_zero_variance), 64'(want.zero_var));
                if (o_pair_count !== want.pair_count)
                    report_mismatch("pair_count", 64'(o_pair_count), 64'(want.pair_count));
                if (o_total_x !== want.total_x)
                    report_mismatch("total_x", 64'(o_total_x), 64'(want.total_x));
                if (o_total_y !== want.total_y)
                    report_mismatch("total_y", 64'(o_total_y), 64'(want.total_y));
                if (o_total_xx !== want.total_xx)
                    report_mismatch("total_xx", 64'(o_total_xx), 64'(want.total_xx));
                if (o_total_yy !== want.total_yy)
                    report_mismatch("total_yy", 64'(o_total_yy), 64'(want.total_yy));
                if (o_total_xy !== want.total_xy)
                    report_mismatch("total_xy", 64'(o_total_xy), 64'(want.total_xy));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_x_sample  = '0;
        i_y_sample  = '0;
        i_last_pair = 1'b0;
        sum_n  = 0;
        sum_x  = 0;
        sum_y  = 0;
        sum_xx = 0;
        sum_yy = 0;
        sum_xy = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_pair();
        test_constant_vector();
        test_perfect_positive();
        test_perfect_negative();
        test_extreme_samples();
        test_drain_pause();
        test_random_vectors();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d pairs, checked %0d vector results, %0d of them with zero variance",
                 pairs_sent, results_seen, flat_results);
        $display("coefficient reached +1 in %0d and -1 in %0d results, %0d mismatches",
                 unity_pos, unity_neg, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
